// ----- hdl/nps_pkg.sv -----
package nps_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned RANK_W  = 2;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned SQ_W    = 33;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_POINTS_IN_USE  = 1'b0;
  localparam logic REG_DISTANCE_LIMIT = 1'b1;

  typedef struct packed {
    logic load_query;
    logic write_entry;
    logic rd_point;
    logic sq_start;
    logic sqrt_start;
    logic sqrt_step;
    logic collect;
    logic sort_init;
    logic sort_rd_i;
    logic sort_rd_j;
    logic sort_cmp;
    logic emit;
    logic emit_none;
  } nps_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic in_range;
  } nps_stat_t;

endpackage

// ----- hdl/nearest_point_selector_core.sv -----
// Operation: a table write completes at the edge that accepts it and never raises busy.
// A query handles each point in use in turn (table read, difference, square, bit-serial
// root, compare), then sorts by selection with a read and a write-back per rank and a
// read and a compare per compared pair. Each result appears the cycle after its rank
// settles; busy drops in the cycle after the last result. No new item is taken while busy.
// Reset clears the controller and sets 16 points and limit 16384; results cannot stall.
module nearest_point_selector_core #(
  parameter int unsigned MAX_POINTS   = 16,
  parameter int unsigned MAX_SELECTED = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [3:0]  point_index,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic        found,
  output logic [1:0]  rank,
  output logic [3:0]  point_id,
  output logic [15:0] distance,
  output logic [4:0]  in_range_count,
  output logic        last
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  // Configuration registers; the point count used by the controller saturates at the table depth.
  logic [4:0]  points_in_use;
  logic [15:0] distance_limit;
  logic [IDX_W:0] n_use;

  nps_pkg::nps_cmd_t  cmd;
  nps_pkg::nps_stat_t stat;
  logic [IDX_W-1:0] pt_index, cnt_index, si, sj;
  logic found_c, last_c;
  logic [1:0] rank_c;
  logic [4:0] count_c;
  logic [IDX_W-1:0] wr_idx;
  logic wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use  <= 5'd16;
      distance_limit <= 16'd16384;
    end else if (cfg_we) begin
      if (cfg_index == nps_pkg::REG_POINTS_IN_USE) points_in_use <= cfg_data[4:0];
      else distance_limit <= cfg_data;
    end
  end

  assign n_use = (32'(points_in_use) > MAX_POINTS) ? (IDX_W+1)'(MAX_POINTS)
                 : (IDX_W+1)'(points_in_use);

  // Writes beyond the table are dropped.
  assign wr_ok  = (32'(point_index) < MAX_POINTS);
  assign wr_idx = IDX_W'(point_index);

  nps_control #(.MAX_POINTS(MAX_POINTS), .MAX_SELECTED(MAX_SELECTED), .IDX_W(IDX_W)) u_ctrl (
    .clk(clk), .rst(rst), .start(start & (wr_ok | command)), .command(command),
    .n_use(n_use), .busy(busy), .cmd(cmd), .stat(stat), .pt_index(pt_index),
    .cnt_index(cnt_index), .si(si), .sj(sj), .found_o(found_c), .rank_o(rank_c),
    .count_o(count_c), .last_o(last_c)
  );

  nps_datapath #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .wr_index(wr_idx),
    .in_x(pos_x), .in_y(pos_y), .pt_index(pt_index), .cnt_index(cnt_index),
    .si(si), .sj(sj), .limit(distance_limit), .found_in(found_c), .rank_in(rank_c),
    .count_in(count_c), .last_in(last_c), .res_valid(result_valid), .found(found),
    .rank(rank), .point_id(point_id), .distance(distance),
    .in_range_count(in_range_count), .last(last)
  );

endmodule

// ----- hdl/nps_datapath.sv -----
module nps_datapath #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nps_pkg::nps_cmd_t          cmd,
  output nps_pkg::nps_stat_t         stat,
  input  logic [IDX_W-1:0]           wr_index,
  input  logic [nps_pkg::COORD_W-1:0] in_x,
  input  logic [nps_pkg::COORD_W-1:0] in_y,
  input  logic [IDX_W-1:0]           pt_index,
  input  logic [IDX_W-1:0]           cnt_index,
  input  logic [IDX_W-1:0]           si,
  input  logic [IDX_W-1:0]           sj,
  input  logic [nps_pkg::DIST_W-1:0] limit,
  input  logic                       found_in,
  input  logic [nps_pkg::RANK_W-1:0] rank_in,
  input  logic [nps_pkg::CNT_W-1:0]  count_in,
  input  logic                       last_in,
  output logic                       res_valid,
  output logic                       found,
  output logic [nps_pkg::RANK_W-1:0] rank,
  output logic [nps_pkg::ID_W-1:0]   point_id,
  output logic [nps_pkg::DIST_W-1:0] distance,
  output logic [nps_pkg::CNT_W-1:0]  in_range_count,
  output logic                       last
);

  logic [nps_pkg::COORD_W-1:0] mem_x [MAX_POINTS];
  logic [nps_pkg::COORD_W-1:0] mem_y [MAX_POINTS];
  logic [nps_pkg::DIST_W-1:0]  mem_d [MAX_POINTS];
  logic [IDX_W-1:0]            mem_i [MAX_POINTS];

  logic [nps_pkg::COORD_W-1:0] qx, qy, px, py;
  logic [nps_pkg::COORD_W-1:0] dx, dy;
  logic [2*nps_pkg::COORD_W-1:0] sq_x, sq_y;
  logic [nps_pkg::SQ_W-1:0]    rem;
  logic [nps_pkg::SQ_W-1:0]    root;
  logic [nps_pkg::SQ_W-1:0]    bitv;
  logic [nps_pkg::SQ_W-1:0]    trial;
  logic [nps_pkg::DIST_W-1:0]  dist_sat;
  logic [nps_pkg::DIST_W-1:0]  best_d, cand_d;
  logic [IDX_W-1:0]            best_i, cand_i;

  assign sq_x  = dx * dx;
  assign sq_y  = dy * dy;
  assign trial = root + bitv;
  assign dist_sat = (root[nps_pkg::SQ_W-1:nps_pkg::DIST_W] != '0) ? '1
                    : root[nps_pkg::DIST_W-1:0];
  assign stat = '{sqrt_done: (bitv == '0), in_range: (dist_sat < limit)};

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx <= in_x;
      qy <= in_y;
    end
    if (cmd.write_entry) begin
      mem_x[wr_index] <= in_x;
      mem_y[wr_index] <= in_y;
    end
    if (cmd.rd_point) begin
      px <= mem_x[pt_index];
      py <= mem_y[pt_index];
    end
    if (cmd.sq_start) begin
      dx <= (qx > px) ? qx - px : px - qx;
      dy <= (qy > py) ? qy - py : py - qy;
    end
    // Two 16x16 squares are summed; the root starts at the top power of four.
    if (cmd.sqrt_start) begin
      rem  <= {1'b0, sq_x} + {1'b0, sq_y};
      root <= '0;
      bitv <= {1'b1, {(nps_pkg::SQ_W-1){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.collect) begin
      mem_d[cnt_index] <= dist_sat;
      mem_i[cnt_index] <= pt_index;
    end
    if (cmd.sort_rd_i) begin
      best_d <= mem_d[si];
      best_i <= mem_i[si];
    end
    if (cmd.sort_rd_j) begin
      cand_d <= mem_d[sj];
      cand_i <= mem_i[sj];
    end
    if (cmd.sort_cmp && (cand_d < best_d)) begin
      mem_d[sj] <= best_d;
      mem_i[sj] <= best_i;
      best_d    <= cand_d;
      best_i    <= cand_i;
    end
    if (cmd.sort_init) begin
      mem_d[si] <= best_d;
      mem_i[si] <= best_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.emit | cmd.emit_none;
    end
    found          <= found_in;
    rank           <= rank_in;
    in_range_count <= count_in;
    last           <= last_in;
    point_id       <= cmd.emit_none ? '0 : nps_pkg::ID_W'(best_i);
    distance       <= cmd.emit_none ? '0 : best_d;
  end

endmodule

// ----- hdl/nps_control.sv -----
module nps_control #(
  parameter int unsigned MAX_POINTS   = 16,
  parameter int unsigned MAX_SELECTED = 4,
  parameter int unsigned IDX_W        = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       command,
  input  logic [IDX_W:0]             n_use,
  output logic                       busy,
  output nps_pkg::nps_cmd_t          cmd,
  input  nps_pkg::nps_stat_t         stat,
  output logic [IDX_W-1:0]           pt_index,
  output logic [IDX_W-1:0]           cnt_index,
  output logic [IDX_W-1:0]           si,
  output logic [IDX_W-1:0]           sj,
  output logic                       found_o,
  output logic [nps_pkg::RANK_W-1:0] rank_o,
  output logic [nps_pkg::CNT_W-1:0]  count_o,
  output logic                       last_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDPT  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_KEEP  = 4'd5;
  localparam logic [3:0] S_RDI   = 4'd6;
  localparam logic [3:0] S_RDJ   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_PUT   = 4'd9;
  localparam logic [3:0] S_NONE  = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [3:0]   state;
  logic [IDX_W:0] pt, cnt, i_r, j_r, sel;

  assign busy      = (state != S_IDLE);
  assign pt_index  = pt[IDX_W-1:0];
  assign cnt_index = cnt[IDX_W-1:0];
  assign si        = i_r[IDX_W-1:0];
  assign sj        = j_r[IDX_W-1:0];
  assign sel       = (cnt < (IDX_W+1)'(MAX_SELECTED)) ? cnt : (IDX_W+1)'(MAX_SELECTED);

  always_comb begin
    cmd = '0;
    cmd.load_query  = (state == S_IDLE) && start;
    cmd.write_entry = (state == S_IDLE) && start && (command == nps_pkg::CMD_WRITE);
    cmd.rd_point    = (state == S_RDPT);
    cmd.sq_start    = (state == S_DIFF);
    cmd.sqrt_start  = (state == S_SQ);
    cmd.sqrt_step   = (state == S_ROOT) && !stat.sqrt_done;
    cmd.collect     = (state == S_KEEP) && stat.in_range;
    cmd.sort_rd_i   = (state == S_RDI);
    cmd.sort_rd_j   = (state == S_RDJ);
    cmd.sort_cmp    = (state == S_CMP);
    cmd.sort_init   = (state == S_PUT);
    cmd.emit        = (state == S_PUT);
    cmd.emit_none   = (state == S_NONE);
  end

  always_comb begin
    found_o = (state == S_PUT);
    rank_o  = (state == S_PUT) ? nps_pkg::RANK_W'(i_r) : '0;
    count_o = (state == S_PUT) ? nps_pkg::CNT_W'(cnt) : '0;
    last_o  = (state == S_NONE) || ((i_r + 1'b1) == sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pt <= '0;
      cnt <= '0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && (command == nps_pkg::CMD_QUERY)) begin
            pt  <= '0;
            cnt <= '0;
            state <= (n_use == '0) ? S_NONE : S_RDPT;
          end
        end
        S_RDPT: state <= S_DIFF;
        S_DIFF: state <= S_SQ;
        S_SQ:   state <= S_ROOT;
        S_ROOT: if (stat.sqrt_done) state <= S_KEEP;
        S_KEEP: begin
          if (stat.in_range) cnt <= cnt + 1'b1;
          if ((pt + 1'b1) == n_use) begin
            i_r <= '0;
            state <= (stat.in_range || cnt != '0) ? S_RDI : S_NONE;
          end else begin
            pt <= pt + 1'b1;
            state <= S_RDPT;
          end
        end
        S_RDI: begin
          j_r <= i_r + 1'b1;
          state <= ((i_r + 1'b1) < cnt) ? S_RDJ : S_PUT;
        end
        S_RDJ: state <= S_CMP;
        S_CMP: begin
          j_r <= j_r + 1'b1;
          state <= ((j_r + 1'b1) < cnt) ? S_RDJ : S_PUT;
        end
        S_PUT: begin
          i_r <= i_r + 1'b1;
          state <= ((i_r + 1'b1) == sel) ? S_WAIT : S_RDI;
        end
        S_NONE: state <= S_WAIT;
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/nps_checker.sv -----
module nps_assert (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       result_valid,
  input logic       found,
  input logic [1:0] rank,
  input logic       last
);

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result right after reset");
  a_not_found_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (last && rank == 2'd0))
    else $error("not-found result must be final");
  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result while idle");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result after last");

endmodule

bind nearest_point_selector_core nps_assert u_nps_checker (
  .clk(clk), .rst(rst), .busy(busy), .result_valid(result_valid),
  .found(found), .rank(rank), .last(last)
);

// ----- tb/nps_checker.sv -----
`timescale 1ns / 100ps

// Watches the command, configuration and result channels of the nearest point
// selector, predicts every result and compares it field by field.
module nps_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [3:0]  point_index,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        result_valid,
  input  logic        found,
  input  logic [1:0]  rank,
  input  logic [3:0]  point_id,
  input  logic [15:0] distance,
  input  logic [4:0]  in_range_count,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          misses_seen
);

  typedef struct {
    bit        hit;
    bit [1:0]  rank;
    bit [3:0]  id;
    bit [15:0] d_val;
    bit [4:0]  count;
    bit        last;
  } nearest_t;

  nearest_t  nearest_q[$];
  bit [15:0] coord_x[16];
  bit [15:0] coord_y[16];
  bit [4:0]  use_count;
  bit [15:0] dist_limit;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    misses_seen  = 0;
  end

  // Floored Euclidean distance, saturated to 16 bits.
  function automatic bit [15:0] floor_distance(bit [15:0] ax, bit [15:0] ay,
                                               bit [15:0] bx, bit [15:0] by);
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return (root > 65535) ? 16'hFFFF : root[15:0];
  endfunction

  task automatic predict_query(bit [15:0] qx, bit [15:0] qy);
    bit [15:0] d_list[16];
    bit [3:0]  i_list[16];
    bit [15:0] d;
    bit [15:0] best;
    bit [15:0] td;
    bit [3:0]  ti;
    int        n;
    int        count;
    int        sel;
    nearest_t  r;
    n = (use_count > 16) ? 16 : use_count;
    count = 0;
    for (int i = 0; i < n; i++) begin
      d = floor_distance(qx, qy, coord_x[i], coord_y[i]);
      if (d < dist_limit) begin
        d_list[count] = d;
        i_list[count] = 4'(i);
        count++;
      end
    end
    if (count == 0) begin
      r = '{hit: 0, rank: 0, id: 0, d_val: 0, count: 0, last: 1};
      nearest_q.push_back(r);
      return;
    end
    sel = (count < 4) ? count : 4;
    // Swapping selection: a later entry takes the slot only when strictly closer.
    for (int i = 0; i < sel; i++) begin
      best = d_list[i];
      for (int j = i + 1; j < count; j++) begin
        if (d_list[j] < best) begin
          td = d_list[j];
          ti = i_list[j];
          d_list[j] = d_list[i];
          i_list[j] = i_list[i];
          d_list[i] = td;
          i_list[i] = ti;
          best = td;
        end
      end
      r = '{hit: 1, rank: 2'(i), id: i_list[i], d_val: d_list[i], count: 5'(count),
            last: (i + 1 == sel)};
      nearest_q.push_back(r);
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    nearest_t e;
    if (rst) begin
      use_count  = 5'd16;
      dist_limit = 16'd16384;
      nearest_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == nps_pkg::REG_POINTS_IN_USE) use_count = cfg_data[4:0];
        else if (cfg_index == nps_pkg::REG_DISTANCE_LIMIT) dist_limit = cfg_data;
      end
      if (start && !busy) begin
        if (command == nps_pkg::CMD_WRITE) begin
          coord_x[point_index] = pos_x;
          coord_y[point_index] = pos_y;
        end else begin
          predict_query(pos_x, pos_y);
        end
      end
      if (result_valid) begin
        results_seen++;
        if (!found) misses_seen++;
        if (nearest_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual id %0d distance %0d",
                   $time, point_id, distance);
          fail_count++;
        end else begin
          e = nearest_q.pop_front();
          check_field("found", e.hit, found);
          check_field("rank", e.rank, rank);
          check_field("point_id", e.id, point_id);
          check_field("distance", e.d_val, distance);
          check_field("in_range_count", e.count, in_range_count);
          check_field("last", e.last, last);
        end
      end
    end
    pending = nearest_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

// Top of the nearest point selector bench. It only drives items and register
// writes; the checker beside the block does all prediction and comparison.
module tb_top;

  // Cycles with no item accepted and no result seen before the run is declared hung.
  // This is a wide margin over the longest, full 16-point query.
  localparam int IDLE_LIMIT = 5000;
  // Quiet cycles allowed after the last result, covering a trailing table write.
  localparam int SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = nps_pkg::CMD_WRITE;
  logic [3:0]  point_index = '0;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = nps_pkg::REG_POINTS_IN_USE;
  logic [15:0] cfg_data = '0;
  logic        result_valid;
  logic        found;
  logic [1:0]  rank;
  logic [3:0]  point_id;
  logic [15:0] distance;
  logic [4:0]  in_range_count;
  logic        last;

  int fail_count;
  int pending;
  int results_seen;
  int misses_seen;
  int idle_cycles = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  nearest_point_selector_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .point_index(point_index), .pos_x(pos_x), .pos_y(pos_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .found(found), .rank(rank), .point_id(point_id),
    .distance(distance), .in_range_count(in_range_count), .last(last)
  );

  nps_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .point_index(point_index), .pos_x(pos_x), .pos_y(pos_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .found(found), .rank(rank), .point_id(point_id),
    .distance(distance), .in_range_count(in_range_count), .last(last),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .misses_seen(misses_seen)
  );

  // Watchdog: any accepted item or any result resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results still expected", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Presents one item at the current rising edge and returns at the edge that
  // accepts it. Start is left high so back-to-back items never drop it.
  task automatic send_item(logic cmd, logic [3:0] idx, logic [15:0] x, logic [15:0] y);
    start       <= 1'b1;
    command     <= cmd;
    point_index <= idx;
    pos_x       <= x;
    pos_y       <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (cmd == nps_pkg::CMD_QUERY) queries_sent++;
  endtask

  // Bursty sender: after each item, either keep going or take a random break.
  task automatic sender_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected result is back and the block has gone quiet.
  // A table write makes no result, so a fixed settle follows the handshake wait.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly inside the unit square; now and then any 16-bit value.
  function automatic logic [15:0] any_coord();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 32768));
  endfunction

  // A coordinate close to a center, so that queries find points in range.
  function automatic logic [15:0] near_coord(logic [15:0] center, int spread);
    int v;
    v = int'(center) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Register settings for the random phases: count of points in use, then limit.
  // They cover zero points, one point, a count above the table that must
  // saturate, a zero limit, the full-diagonal limit and the largest limit.
  int unsigned phase_use[8]   = '{16, 4, 31, 0, 1, 16, 9, 16};
  int unsigned phase_limit[8] = '{16384, 46341, 8000, 20000, 65535, 0, 3000, 46341};

  initial begin
    logic [15:0] cx;
    logic [15:0] cy;
    int          spread;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Every entry is written before the first query so that no
    // query ever reads an unwritten entry. The corners, the 1.0 point, the
    // largest 16-bit coordinate and two identical points (a tie) are placed.
    send_item(nps_pkg::CMD_WRITE, 4'd0, 16'd0, 16'd0);
    send_item(nps_pkg::CMD_WRITE, 4'd1, 16'd32768, 16'd32768);
    send_item(nps_pkg::CMD_WRITE, 4'd2, 16'hFFFF, 16'hFFFF);
    send_item(nps_pkg::CMD_WRITE, 4'd3, 16'd32768, 16'd0);
    send_item(nps_pkg::CMD_WRITE, 4'd4, 16'd0, 16'd32768);
    send_item(nps_pkg::CMD_WRITE, 4'd5, 16'd16384, 16'd16384);
    send_item(nps_pkg::CMD_WRITE, 4'd6, 16'd16384, 16'd16384);
    send_item(nps_pkg::CMD_WRITE, 4'd7, 16'hFFFF, 16'd0);
    for (int i = 8; i < 16; i++) begin
      send_item(nps_pkg::CMD_WRITE, 4'(i), 16'(16000 + i * 100), 16'(16000 + i * 50));
    end
    send_item(nps_pkg::CMD_QUERY, 4'd0, 16'd0, 16'd0);
    send_item(nps_pkg::CMD_QUERY, 4'd15, 16'd16384, 16'd16384);
    send_item(nps_pkg::CMD_QUERY, 4'd9, 16'd32768, 16'd32768);
    send_item(nps_pkg::CMD_QUERY, 4'd3, 16'hFFFF, 16'hFFFF);
    send_item(nps_pkg::CMD_QUERY, 4'd0, 16'hFFFF, 16'd0);
    // The sender holds off here until every result so far has come back.
    drain();

    // Random part: one phase per register setting, written while the block is idle.
    for (int p = 0; p < 8; p++) begin
      write_reg(nps_pkg::REG_POINTS_IN_USE, 16'(phase_use[p]));
      write_reg(nps_pkg::REG_DISTANCE_LIMIT, 16'(phase_limit[p]));
      // Upper data bits set too: only the low five count for the point register.
      if (p == 2) write_reg(nps_pkg::REG_POINTS_IN_USE, 16'hFFE0 | 16'(phase_use[p]));
      @(posedge clk);
      for (int k = 0; k < 60; k++) begin
        // A cluster center per few items keeps distances below the limit often.
        if (k % 8 == 0) begin
          cx = any_coord();
          cy = any_coord();
          spread = ($urandom_range(0, 1) == 0) ? 1500 : 9000;
        end
        if ($urandom_range(0, 9) < 4) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(nps_pkg::CMD_WRITE, 4'($urandom_range(0, 15)), any_coord(),
                      any_coord());
          end else begin
            send_item(nps_pkg::CMD_WRITE, 4'($urandom_range(0, 15)),
                      near_coord(cx, spread), near_coord(cy, spread));
          end
        end else begin
          send_item(nps_pkg::CMD_QUERY, 4'($urandom_range(0, 15)),
                    near_coord(cx, spread), near_coord(cy, spread));
        end
        sender_pace();
      end
      drain();
    end

    // Everything is drained at this point; give trailing results a last chance.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d queries) over 8 register settings.",
             items_sent, queries_sent);
    $display("Checked %0d results, %0d of them reporting no point in range.",
             results_seen, misses_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
